/* rtl/dit_pkg.sv */
// types, codes and constants shared by the init table interpreter
// no dependencies

package dit_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;

  localparam logic [ByteW-1:0] DELAY_MARKER_RESET = 8'h7F;

  localparam logic [KindW-1:0] KIND_CMD   = 2'd0;
  localparam logic [KindW-1:0] KIND_PARAM = 2'd1;
  localparam logic [KindW-1:0] KIND_DELAY = 2'd2;
  localparam logic [KindW-1:0] KIND_DROP  = 2'd3;

  typedef enum logic [1:0] {
    PH_CMD   = 2'd0,
    PH_LEN   = 2'd1,
    PH_PARAM = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [ByteW-1:0] held_command;
    logic [ByteW-1:0] params_left;
  } parse_state_t;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] value;
    logic             ends_transfer;
    logic             truncated;
  } result_t;

endpackage

/* rtl/dit_step.sv */
// record parser step: one table byte against the parse state
// gives the next parse state and at most one write; uses dit_pkg

module dit_step (
  input  dit_pkg::parse_state_t      state,
  input  logic [dit_pkg::ByteW-1:0]  delay_marker,
  input  logic [dit_pkg::ByteW-1:0]  table_byte,
  input  logic                       table_end,
  output dit_pkg::parse_state_t      state_nxt,
  output dit_pkg::result_t           res
);
  import dit_pkg::*;

  logic [ByteW-1:0] left_dec;

  assign left_dec = state.params_left - ByteW'(1);

  always_comb begin
    state_nxt         = state;
    res.valid         = 1'b0;
    res.kind          = KIND_CMD;
    res.value         = table_byte;
    res.ends_transfer = 1'b0;
    res.truncated     = 1'b0;
    case (state.phase)
      PH_LEN: begin
        res.valid = 1'b1;
        if (state.held_command == delay_marker) begin
          res.kind        = KIND_DELAY;
          state_nxt.phase = PH_CMD;
        end else begin
          res.kind  = KIND_CMD;
          res.value = state.held_command;
          if (table_byte == '0) begin
            res.ends_transfer = 1'b1;
            state_nxt.phase   = PH_CMD;
          end else if (table_end) begin
            res.ends_transfer     = 1'b1;
            res.truncated         = 1'b1;
            state_nxt.phase       = PH_CMD;
            state_nxt.params_left = '0;
          end else begin
            state_nxt.params_left = table_byte;
            state_nxt.phase       = PH_PARAM;
          end
        end
      end
      PH_PARAM: begin
        res.valid             = 1'b1;
        res.kind              = KIND_PARAM;
        state_nxt.params_left = left_dec;
        if (left_dec == '0) begin
          res.ends_transfer = 1'b1;
          state_nxt.phase   = PH_CMD;
        end else if (table_end) begin
          res.ends_transfer     = 1'b1;
          res.truncated         = 1'b1;
          state_nxt.params_left = '0;
          state_nxt.phase       = PH_CMD;
        end
      end
      default: begin
        state_nxt.held_command = table_byte;
        if (table_end) begin
          res.valid       = 1'b1;
          res.kind        = KIND_DROP;
          res.truncated   = 1'b1;
          state_nxt.phase = PH_CMD;
        end else begin
          state_nxt.phase = PH_LEN;
        end
      end
    endcase
  end

endmodule

/* rtl/display_init_table_interpreter.sv */
// init table interpreter top: input register, parse state, result register
// a byte waits in the input register; its write then goes to the result register
// throughput: one table byte per cycle unless the output stalls, set by the single parse-state update
// a byte is taken into an empty input register while a finished write still waits at the output
// reset (synchronous, active low) clears the beats in flight, the parse state
// and sets the delay marker to 0x7F; uses dit_pkg and dit_step

module display_init_table_interpreter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [dit_pkg::ByteW-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dit_pkg::ByteW-1:0]   in_table_byte,
  input  logic                        in_table_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dit_pkg::KindW-1:0]   out_kind,
  output logic [dit_pkg::ByteW-1:0]   out_value,
  output logic                        out_ends_transfer,
  output logic                        out_truncated
);
  import dit_pkg::*;

  logic [ByteW-1:0] delay_marker_r;
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_end_r;
  parse_state_t     state_r;
  parse_state_t     state_nxt;
  result_t          res;
  logic             out_valid_r;
  logic [KindW-1:0] out_kind_r;
  logic [ByteW-1:0] out_value_r;
  logic             out_ends_r;
  logic             out_trunc_r;

  logic out_free;
  logic s1_fire;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  dit_step u_step (
    .state        (state_r),
    .delay_marker (delay_marker_r),
    .table_byte   (s1_byte_r),
    .table_end    (s1_end_r),
    .state_nxt    (state_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_marker_r <= DELAY_MARKER_RESET;
      s1_valid_r     <= 1'b0;
      state_r        <= '{phase: PH_CMD, held_command: '0, params_left: '0};
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        delay_marker_r <= cfg_wr_data;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_fire && res.valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_table_byte;
      s1_end_r  <= in_table_end;
    end
    if (s1_fire && res.valid) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
      out_ends_r  <= res.ends_transfer;
      out_trunc_r <= res.truncated;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_value         = out_value_r;
  assign out_ends_transfer = out_ends_r;
  assign out_truncated     = out_trunc_r;

endmodule

/* rtl/dit_checker.sv */
// port-level checks on the init table interpreter's result beats
// bound to display_init_table_interpreter; uses dit_pkg

module dit_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [dit_pkg::KindW-1:0]   out_kind,
  input logic [dit_pkg::ByteW-1:0]   out_value,
  input logic                        out_ends_transfer,
  input logic                        out_truncated
);
  import dit_pkg::*;

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_ends_transfer) && $stable(out_truncated))
    else $error("stalled result beat changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DROP |-> out_truncated && !out_ends_transfer)
    else $error("dropped command beat not flagged as cut short");

  a_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DELAY |-> !out_truncated && !out_ends_transfer)
    else $error("delay request carries transfer flags");

  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_ends_transfer || out_kind == KIND_DROP)
    else $error("cut-short record did not release the transfer");

endmodule

bind display_init_table_interpreter dit_checker u_dit_checker (.*);

/* bench/tb_display_init_table_interpreter.sv */
// testbench for display_init_table_interpreter: directed table bytes, then random
// init tables under several delay markers and idle patterns, all checked in order
// depends on dit_pkg and the interpreter rtl
module tb_display_init_table_interpreter;
  import dit_pkg::*;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] value;
    logic             ends_transfer;
    logic             truncated;
  } spi_write_t;

  typedef struct packed {
    logic [ByteW-1:0] table_byte;
    logic             table_end;
    bit               typed;
    bit               has_write;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] value;
    logic             ends_transfer;
    logic             truncated;
  } directed_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE     = 2'd0,
    IDLE_SENDER   = 2'd1,
    IDLE_RECEIVER = 2'd2,
    IDLE_BOTH     = 2'd3
  } idle_mode_t;

  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;
  localparam int PhaseBytes = 180;
  localparam int HoldCycles = 240;
  localparam int TimeoutCycles = 200000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [ByteW-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_table_byte = '0;
  logic             in_table_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KindW-1:0] out_kind;
  logic [ByteW-1:0] out_value;
  logic             out_ends_transfer;
  logic             out_truncated;

  // interpreter state mirrored by the predictor
  phase_t           parse_phase = PH_CMD;
  logic [ByteW-1:0] held_cmd = '0;
  logic [ByteW-1:0] params_left = '0;
  logic [ByteW-1:0] delay_marker = DELAY_MARKER_RESET;

  spi_write_t pending_writes[$];
  int         mismatches = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  bit         hold_req = 1'b0;
  int         hold_left = 0;

  directed_row_t directed_rows[24] = '{
    {8'h00, 1'b1, TYPED,     1'b1, KIND_DROP,  8'h00, 1'b0, 1'b1},
    {8'hFF, 1'b0, TYPED,     1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h00, 1'b0, TYPED,     1'b1, KIND_CMD,   8'hFF, 1'b1, 1'b0},
    {8'h7F, 1'b0, TYPED,     1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h00, 1'b0, TYPED,     1'b1, KIND_DELAY, 8'h00, 1'b0, 1'b0},
    {8'h7F, 1'b0, TYPED,     1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'hFF, 1'b1, TYPED,     1'b1, KIND_DELAY, 8'hFF, 1'b0, 1'b0},
    {8'h2A, 1'b0, TYPED,     1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h02, 1'b0, PREDICTED, 1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h00, 1'b0, PREDICTED, 1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'hFF, 1'b1, PREDICTED, 1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h11, 1'b0, TYPED,     1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h03, 1'b1, TYPED,     1'b1, KIND_CMD,   8'h11, 1'b1, 1'b1},
    {8'h36, 1'b0, TYPED,     1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'hFF, 1'b0, PREDICTED, 1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'hA5, 1'b0, PREDICTED, 1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h5A, 1'b1, TYPED,     1'b1, KIND_PARAM, 8'h5A, 1'b1, 1'b1},
    {8'h80, 1'b0, TYPED,     1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h01, 1'b0, PREDICTED, 1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h55, 1'b0, PREDICTED, 1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h01, 1'b0, TYPED,     1'b0, KIND_CMD,   8'h00, 1'b0, 1'b0},
    {8'h00, 1'b1, TYPED,     1'b1, KIND_CMD,   8'h01, 1'b1, 1'b0},
    {8'hFF, 1'b1, TYPED,     1'b1, KIND_DROP,  8'hFF, 1'b0, 1'b1},
    {8'h7F, 1'b1, TYPED,     1'b1, KIND_DROP,  8'h7F, 1'b0, 1'b1}
  };

  display_init_table_interpreter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_table_byte     (in_table_byte),
    .in_table_end      (in_table_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_ends_transfer (out_ends_transfer),
    .out_truncated     (out_truncated)
  );

  always #6 clk = ~clk;

  function automatic bit interpret_byte(input logic [ByteW-1:0] b, input logic last,
                                        output spi_write_t w);
    w = '0;
    case (parse_phase)
      PH_LEN: begin
        parse_phase = PH_CMD;
        if (held_cmd == delay_marker) begin
          w = {KIND_DELAY, b, 1'b0, 1'b0};
        end else if (b == '0) begin
          w = {KIND_CMD, held_cmd, 1'b1, 1'b0};
        end else if (last) begin
          w = {KIND_CMD, held_cmd, 1'b1, 1'b1};
          params_left = '0;
        end else begin
          w = {KIND_CMD, held_cmd, 1'b0, 1'b0};
          params_left = b;
          parse_phase = PH_PARAM;
        end
        return 1'b1;
      end
      PH_PARAM: begin
        params_left = params_left - 1'b1;
        if (params_left == '0) begin
          w = {KIND_PARAM, b, 1'b1, 1'b0};
          parse_phase = PH_CMD;
        end else if (last) begin
          w = {KIND_PARAM, b, 1'b1, 1'b1};
          params_left = '0;
          parse_phase = PH_CMD;
        end else begin
          w = {KIND_PARAM, b, 1'b0, 1'b0};
        end
        return 1'b1;
      end
      default: begin
        held_cmd = b;
        if (last) begin
          w = {KIND_DROP, b, 1'b0, 1'b1};
          parse_phase = PH_CMD;
          return 1'b1;
        end
        parse_phase = PH_LEN;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 25) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // called at a clock edge; returns at the edge where the beat was taken
  task automatic send_beat(input logic [ByteW-1:0] b, input logic last, input bit typed,
                           input bit typed_has, input spi_write_t typed_w);
    int         gap_pct;
    bit         got;
    spi_write_t w;
    gap_pct = (idle_mode == IDLE_SENDER) ? 66 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_table_byte <= b;
    in_table_end <= last;
    do @(posedge clk); while (in_stall);
    got = interpret_byte(b, last, w);
    if (typed) begin
      got = typed_has;
      w = typed_w;
    end
    if (got) pending_writes.push_back(w);
  endtask

  task automatic drain_writes();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic set_delay_marker(input logic [ByteW-1:0] v);
    drain_writes();
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    delay_marker = v;
  endtask

  task automatic send_table(inout int sent);
    logic [ByteW-1:0] tbl[$];
    logic [ByteW-1:0] cmd;
    int               len;
    int               r;
    int               cut;
    if ($urandom_range(0, 9) == 0) begin
      // noise: random bytes and random table ends
      repeat ($urandom_range(1, 12)) begin
        send_beat(8'($urandom), $urandom_range(0, 7) == 0, PREDICTED, 1'b0, '0);
        sent++;
      end
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      cmd = ($urandom_range(0, 4) == 0) ? delay_marker : 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 45) len = $urandom_range(0, 3);
      else if (r < 98) len = $urandom_range(4, 16);
      else len = $urandom_range(17, 255);
      tbl.push_back(cmd);
      if (cmd == delay_marker) begin
        tbl.push_back(8'($urandom));
      end else begin
        tbl.push_back(8'(len));
        repeat (len) tbl.push_back(8'($urandom));
      end
    end
    cut = tbl.size() - 1;
    if ($urandom_range(0, 5) == 0) cut = $urandom_range(0, tbl.size() - 1);
    for (int i = 0; i <= cut; i++) begin
      send_beat(tbl[i], i == cut, PREDICTED, 1'b0, '0);
      sent++;
    end
  endtask

  // receiver: long hold-off on request, otherwise random stalls per mode
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_stall <= $urandom_range(0, 99) < 66;
        IDLE_BOTH:     out_stall <= $urandom_range(0, 99) < 11;
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    spi_write_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write kind %0d value %02h", out_kind, out_value));
      end else begin
        want = pending_writes.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_value !== want.value)
          report_mismatch($sformatf("value %02h, want %02h", out_value, want.value));
        if (out_ends_transfer !== want.ends_transfer)
          report_mismatch($sformatf("ends_transfer %b, want %b", out_ends_transfer,
                                    want.ends_transfer));
        if (out_truncated !== want.truncated)
          report_mismatch($sformatf("truncated %b, want %b", out_truncated, want.truncated));
      end
    end
  end

  initial begin
    logic [ByteW-1:0] markers[6];
    int               sent;
    bit               paused;
    markers = '{8'h00, 8'hFF, 8'($urandom), DELAY_MARKER_RESET, 8'h80, 8'($urandom)};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].table_byte, directed_rows[i].table_end,
                directed_rows[i].typed, directed_rows[i].has_write,
                {directed_rows[i].kind, directed_rows[i].value,
                 directed_rows[i].ends_transfer, directed_rows[i].truncated});
    end
    for (int p = 0; p < 6; p++) begin
      set_delay_marker(markers[p]);
      idle_mode = idle_mode_t'(p % 4);
      // block fills up behind a long receiver hold-off
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      paused = 1'b0;
      while (sent < PhaseBytes) begin
        send_table(sent);
        if (!paused && sent >= PhaseBytes / 2) begin
          drain_writes();
          paused = 1'b1;
        end
      end
    end
    drain_writes();
    repeat (8) @(posedge clk);
    if (pending_writes.size() != 0) report_mismatch("writes still outstanding at end");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 12);
    $display("Verification failed");
    $finish;
  end

endmodule
